// ----- rtl/core/lhbp_pkg.sv -----
// ----------------------------------------------------------------------------
// lhbp_pkg
// Shared constants and types of the local history branch predictor.
// ----------------------------------------------------------------------------
package lhbp_pkg;

   // Field widths
   localparam int IDX_W       = 16;  // instruction index
   localparam int CFG_W       = 3;   // entries_log2 register
   localparam int ENTRY_OUT_W = 4;   // entry_index result field
   localparam int MISS_W      = 16;  // miss counter
   localparam int CTR_W       = 2;   // pattern counter

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;

   // Entry selection: entries_log2 above this limit is clamped
   localparam logic [CFG_W-1:0] LOG2_LIMIT  = 3'd4;
   localparam int               ENTRY_SPAN  = 1 << ENTRY_OUT_W;
   localparam logic [CFG_W-1:0] CFG_RESET   = 3'd1;

   // Counter thresholds
   localparam logic [CTR_W-1:0] CTR_MAX         = 2'd3;
   localparam logic [CTR_W-1:0] CTR_MIN         = 2'd0;
   localparam logic [CTR_W-1:0] TAKEN_THRESHOLD = 2'd2;

   // Default geometry
   localparam int DEF_MAX_ENTRIES    = 16;
   localparam int DEF_HISTORY_LENGTH = 3;

   // Controller to datapath commands
   typedef struct packed {
      logic load;    // input transfer: latch item, start row read
      logic commit;  // row data valid: update row, load result register
   } lhbp_cmd_type;

endpackage

// ----- rtl/core/lhbp_ram.sv -----
// ----------------------------------------------------------------------------
// lhbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lhbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/lhbp_ctrl.sv -----
// ----------------------------------------------------------------------------
// lhbp_ctrl
// Sequencer: accepts an item, waits for its row read, commits the update
// when the result register is free.
// ----------------------------------------------------------------------------
module lhbp_ctrl
   import lhbp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output lhbp_cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_CALC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            // hold until the previous result has been taken
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/core/lhbp_dpath.sv -----
// ----------------------------------------------------------------------------
// lhbp_dpath
// Entry selection, predictor row storage and read-modify-write update.
// One row per entry holds miss count, pattern counters and local history.
// ----------------------------------------------------------------------------
module lhbp_dpath
   import lhbp_pkg::*;
#(
   parameter int MAX_ENTRIES    = DEF_MAX_ENTRIES,
   parameter int HISTORY_LENGTH = DEF_HISTORY_LENGTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lhbp_cmd_type           cmd,
   input  logic [IDX_W-1:0]       instr_index,
   input  logic                   taken,
   input  logic [CFG_W-1:0]       cfg_data,
   input  logic                   cfg_write,
   output logic [ENTRY_OUT_W-1:0] entry_index,
   output logic                   predicted_taken,
   output logic                   mispredicted,
   output logic [MISS_W-1:0]      miss_count
);

   localparam int EIDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int NCTR   = 1 << HISTORY_LENGTH;
   localparam int CROW_W = CTR_W * NCTR;
   localparam int ROW_W  = MISS_W + CROW_W + HISTORY_LENGTH;

   // wrap of a selected entry number into the storage range
   function automatic logic [ENTRY_SPAN*EIDX_W-1:0] build_wrap();
      logic [ENTRY_SPAN*EIDX_W-1:0] r;
      r = '0;
      for (int i = 0; i < ENTRY_SPAN; i++) begin
         r[i*EIDX_W +: EIDX_W] = EIDX_W'(i % MAX_ENTRIES);
      end
      return r;
   endfunction

   localparam logic [ENTRY_SPAN*EIDX_W-1:0] ENTRY_WRAP = build_wrap();

   logic [CFG_W-1:0]       log2_ff;
   logic [MAX_ENTRIES-1:0] valid_ff;
   logic [EIDX_W-1:0]      entry_ff;
   logic                   taken_ff;
   logic                   hit_ff;

   logic [ENTRY_OUT_W-1:0] ent_out_ff;
   logic                   pred_ff;
   logic                   miss_ff;
   logic [MISS_W-1:0]      miss_cnt_ff;

   logic [CFG_W-1:0]          log2_lim;
   logic [ENTRY_OUT_W-1:0]    sel_mask;
   logic [ENTRY_OUT_W-1:0]    sel_raw;
   logic [EIDX_W-1:0]         entry_sel;

   logic [ROW_W-1:0]          rd_row;
   logic [ROW_W-1:0]          row;
   logic [ROW_W-1:0]          row_in;
   logic [HISTORY_LENGTH-1:0] hist;
   logic [HISTORY_LENGTH-1:0] hist_in;
   logic [CROW_W-1:0]         ctrs;
   logic [CROW_W-1:0]         ctrs_in;
   logic [MISS_W-1:0]         miss_old;
   logic [MISS_W-1:0]         miss_in;
   logic [CTR_W-1:0]          ctr;
   logic [CTR_W-1:0]          ctr_in;
   logic                      pred;
   logic                      miss;

   // entry selection from the incoming index
   always_comb begin
      log2_lim  = (log2_ff > LOG2_LIMIT) ? LOG2_LIMIT : log2_ff;
      sel_mask  = ENTRY_OUT_W'(({{ENTRY_OUT_W{1'b0}}, 1'b1} << log2_lim) - 1'b1);
      sel_raw   = instr_index[ENTRY_OUT_W-1:0] & sel_mask;
      entry_sel = ENTRY_WRAP[sel_raw*EIDX_W +: EIDX_W];
   end

   lhbp_ram #(
      .WIDTH (ROW_W),
      .DEPTH (MAX_ENTRIES)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (entry_ff),
      .wr_data (row_in),
      .rd_en   (cmd.load),
      .rd_addr (entry_sel),
      .rd_data (rd_row)
   );

   // row update
   always_comb begin
      row      = hit_ff ? rd_row : '0;
      hist     = row[HISTORY_LENGTH-1:0];
      ctrs     = row[HISTORY_LENGTH +: CROW_W];
      miss_old = row[HISTORY_LENGTH + CROW_W +: MISS_W];
      ctr      = ctrs[hist*CTR_W +: CTR_W];
      pred     = (ctr >= TAKEN_THRESHOLD);
      miss     = (pred != taken_ff);
      miss_in  = (miss && (miss_old != {MISS_W{1'b1}})) ? miss_old + 1'b1 : miss_old;
      if (taken_ff) begin
         ctr_in = (ctr != CTR_MAX) ? ctr + 1'b1 : ctr;
      end else begin
         ctr_in = (ctr != CTR_MIN) ? ctr - 1'b1 : ctr;
      end
      ctrs_in = ctrs;
      ctrs_in[hist*CTR_W +: CTR_W] = ctr_in;
      hist_in = HISTORY_LENGTH'({hist, taken_ff});
      row_in  = {miss_in, ctrs_in, hist_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         log2_ff  <= CFG_RESET;
         valid_ff <= '0;
      end else begin
         if (cfg_write) begin
            log2_ff <= cfg_data;
         end
         if (cmd.commit) begin
            valid_ff[entry_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         entry_ff <= entry_sel;
         taken_ff <= taken;
         hit_ff   <= valid_ff[entry_sel];
      end
      if (cmd.commit) begin
         ent_out_ff  <= ENTRY_OUT_W'(entry_ff);
         pred_ff     <= pred;
         miss_ff     <= miss;
         miss_cnt_ff <= miss_in;
      end
   end

   assign entry_index     = ent_out_ff;
   assign predicted_taken = pred_ff;
   assign mispredicted    = miss_ff;
   assign miss_count      = miss_cnt_ff;

endmodule

// ----- rtl/core/local_history_branch_predictor.sv -----
// ----------------------------------------------------------------------------
// local_history_branch_predictor
// Two-level local predictor: per-entry history selects a 2-bit counter.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one resolved instruction per transfer (index and outcome).
//   rsp channel: one result per input: entry, prediction made before the
//     update, misprediction flag and the entry's saturating miss count.
//   csr channel: writes entries_log2 (number of entries in use is
//     2^entries_log2, clamped at 16); write only while the block is idle.
// Timing: the entry row is read at the accepting edge and the result is
//   registered when the update commits, which raises rsp_tvalid; the
//   block takes no new item until the current one has committed, as the
//   row RAM read-modify-write requires.
// Stall: while a result waits on rsp_tready the next item is still taken
//   and read; its commit holds until the result register is free.
// Reset: all histories, counters and miss counts read as zero through
//   per-entry valid bits, cleared at once; entries_log2 returns to 1.
// ----------------------------------------------------------------------------
module local_history_branch_predictor
   import lhbp_pkg::*;
#(
   parameter int MAX_ENTRIES    = DEF_MAX_ENTRIES,
   parameter int HISTORY_LENGTH = DEF_HISTORY_LENGTH
) (
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata: [15:0] instr_index, [16] taken, [23:17] zero
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // rsp_tdata: [3:0] entry_index, [4] predicted_taken, [5] mispredicted,
   //            [21:6] miss_count, [23:22] zero
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CFG_W-1:0]       csr_wdata
);

   lhbp_cmd_type           cmd;
   logic [ENTRY_OUT_W-1:0] entry_index;
   logic                   predicted_taken;
   logic                   mispredicted;
   logic [MISS_W-1:0]      miss_count;

   assign csr_ready = 1'b1;

   lhbp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   lhbp_dpath #(
      .MAX_ENTRIES    (MAX_ENTRIES),
      .HISTORY_LENGTH (HISTORY_LENGTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .instr_index     (req_tdata[IDX_W-1:0]),
      .taken           (req_tdata[IDX_W]),
      .cfg_data        (csr_wdata),
      .cfg_write       (csr_valid & csr_ready),
      .entry_index     (entry_index),
      .predicted_taken (predicted_taken),
      .mispredicted    (mispredicted),
      .miss_count      (miss_count)
   );

   assign rsp_tdata = {
      {(RSP_TDATA_W - ENTRY_OUT_W - 2 - MISS_W){1'b0}},
      miss_count, mispredicted, predicted_taken, entry_index
   };

endmodule
